// ===== rtl/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared constants and controller/datapath handshake types for the
// direct-mapped read cache.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

  // geometry
  localparam int LINES      = 8;
  localparam int LINE_BYTES = 16;
  localparam int MEM_BYTES  = 4096;

  // item fields
  localparam int ADDR_W = 12;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 32;
  localparam int TAG_W  = 8;

  // derived widths
  localparam int OFF_W      = $clog2(LINE_BYTES);
  localparam int LINE_W     = $clog2(LINES);
  localparam int MEM_AW     = $clog2(MEM_BYTES);
  localparam int LB_ENTRIES = LINES * LINE_BYTES;
  localparam int LB_AW      = $clog2(LB_ENTRIES);
  localparam int BLK_W      = ADDR_W - OFF_W;

  // stream widths
  localparam int IN_TDATA_W  = ((ADDR_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + 2 * CNT_W + 7) / 8) * 8;

  // reset contents and timing
  localparam logic [TAG_W-1:0]  RESET_TAG    = 8'hFF;
  localparam logic [DATA_W-1:0] RESET_BYTE   = 8'h23;
  localparam logic [CNT_W-1:0]  HIT_TIME     = 32'd1;
  localparam logic [CNT_W-1:0]  MISS_PENALTY = 32'd10;

  // func codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_ACCESS = 1'b1;

  typedef struct packed {
    logic             capture;
    logic             mem_wr;
    logic             lookup;
    logic             fill_rd;
    logic [OFF_W-1:0] fill_idx;
    logic             line_rd;
    logic             out_load;
  } dmc_cmd_t;

  typedef struct packed {
    logic func;
    logic hit;
    logic out_free;
  } dmc_sts_t;

endpackage

`default_nettype wire

// ===== rtl/dmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmc_ctrl
// Sequencer for the cache: load write to backing memory, lookup, line refill
// from backing memory, line read and hand-off to the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire dmc_pkg::dmc_sts_t sts,
  output dmc_pkg::dmc_cmd_t cmd
);
  import dmc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FILL,
    ST_DRAIN,
    ST_READ,
    ST_DONE
  } state_t;

  state_t           state_r;
  state_t           state_nxt;
  logic [OFF_W-1:0] cnt_r;
  logic [OFF_W-1:0] cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cnt_nxt = '0;
        if (sts.func == FUNC_LOAD) begin
          state_nxt = ST_DONE;
        end else if (sts.hit) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == OFF_W'(LINE_BYTES - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state_r == ST_IDLE) && in_tvalid;
    cmd.mem_wr   = (state_r == ST_LOOKUP) && (sts.func == FUNC_LOAD);
    cmd.lookup   = (state_r == ST_LOOKUP) && (sts.func == FUNC_ACCESS);
    cmd.fill_rd  = (state_r == ST_FILL);
    cmd.fill_idx = cnt_r;
    cmd.line_rd  = (state_r == ST_READ);
    cmd.out_load = (state_r == ST_DONE) && sts.out_free;
  end

endmodule

`default_nettype wire

// ===== rtl/dmc_datapath.sv =====
// ----------------------------------------------------------------------------
// dmc_datapath
// Backing memory, line store, tags, time and miss counters and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_datapath (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_func,
  input  wire  [dmc_pkg::ADDR_W-1:0]           in_addr,
  input  wire  [dmc_pkg::DATA_W-1:0]           in_load_data,
  input  wire dmc_pkg::dmc_cmd_t               cmd,
  output dmc_pkg::dmc_sts_t                    sts,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic                                 out_was_miss,
  output logic [dmc_pkg::DATA_W-1:0]           out_read_data,
  output logic [dmc_pkg::CNT_W-1:0]            out_elapsed_time,
  output logic [dmc_pkg::CNT_W-1:0]            out_miss_total
);
  import dmc_pkg::*;

  // captured item
  logic              func_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] ldata_r;

  logic [OFF_W-1:0]  off;
  logic [LINE_W-1:0] line_idx;
  logic [TAG_W-1:0]  tag;
  logic [TAG_W-1:0]  stored_tag;
  logic              hit;

  logic [DATA_W-1:0] mem [MEM_BYTES];
  logic [DATA_W-1:0] mem_q_r;
  logic [ADDR_W-1:0] fill_addr;

  logic [DATA_W-1:0] lb [LB_ENTRIES];
  logic [DATA_W-1:0] lb_q_r;
  logic              pend_r;
  logic [OFF_W-1:0]  pend_idx_r;

  logic [TAG_W-1:0]  tags_r [LINES];
  logic [LINES-1:0]  valid_r;

  logic [CNT_W-1:0]  time_r;
  logic [CNT_W-1:0]  mcnt_r;
  logic              miss_r;

  logic              out_valid_r;
  logic              out_miss_r;
  logic [DATA_W-1:0] out_rd_r;
  logic [CNT_W-1:0]  out_time_r;
  logic [CNT_W-1:0]  out_mcnt_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= in_func;
      addr_r  <= in_addr;
      ldata_r <= in_load_data;
    end
  end

  assign off        = addr_r[OFF_W-1:0];
  assign line_idx   = addr_r[OFF_W +: LINE_W];
  assign tag        = TAG_W'(addr_r[ADDR_W-1:OFF_W+LINE_W]);
  // a line never filled since reset carries the reset tag
  assign stored_tag = valid_r[line_idx] ? tags_r[line_idx] : RESET_TAG;
  assign hit        = (stored_tag == tag);

  assign sts.func     = func_r;
  assign sts.hit      = hit;
  assign sts.out_free = !out_valid_r || out_ready;

  // aligned block address plus the byte being fetched
  assign fill_addr = {addr_r[ADDR_W-1:OFF_W], cmd.fill_idx};

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[MEM_AW'(addr_r)] <= ldata_r;
    end
    if (cmd.fill_rd) begin
      mem_q_r <= mem[MEM_AW'(fill_addr)];
    end
  end

  // fetched byte is registered in mem_q_r and written to the line store from there
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.fill_rd;
    end
    pend_idx_r <= cmd.fill_idx;
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      lb[{line_idx, pend_idx_r}] <= mem_q_r;
    end
    if (cmd.line_rd) begin
      lb_q_r <= lb[{line_idx, off}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      time_r  <= '0;
      mcnt_r  <= '0;
    end else if (cmd.lookup) begin
      if (hit) begin
        time_r <= time_r + HIT_TIME;
      end else begin
        time_r            <= time_r + HIT_TIME + MISS_PENALTY;
        mcnt_r            <= mcnt_r + 1'b1;
        valid_r[line_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      miss_r <= !hit;
      if (!hit) begin
        tags_r[line_idx] <= tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_miss_r <= (func_r == FUNC_ACCESS) && miss_r;
      out_time_r <= time_r;
      out_mcnt_r <= mcnt_r;
      if (func_r == FUNC_ACCESS) begin
        out_rd_r <= valid_r[line_idx] ? lb_q_r : RESET_BYTE;
      end else begin
        out_rd_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_was_miss     = out_miss_r;
  assign out_read_data    = out_rd_r;
  assign out_elapsed_time = out_time_r;
  assign out_miss_total   = out_mcnt_r;

  // a miss bumps the miss count by exactly one
  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup && !hit |=> mcnt_r == $past(mcnt_r) + 1'b1)
    else $error("miss count did not advance on a miss");

  // after any lookup the line holds the requested tag
  a_tag_installed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.lookup |=> hit)
    else $error("line tag not installed after lookup");

  // loads leave both counters untouched
  a_load_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_wr |=> $stable(time_r) && $stable(mcnt_r))
    else $error("load changed a counter");

  // line store is only written during the refill of a missed access
  a_fill_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (func_r == FUNC_ACCESS) && miss_r)
    else $error("line store written outside a refill");

endmodule

`default_nettype wire

// ===== rtl/direct_mapped_cache_read.sv =====
// ----------------------------------------------------------------------------
// direct_mapped_cache_read
// Direct-mapped read cache, 8 lines of 16 bytes, over a 4096-byte backing
// memory, with running time and miss counters.
// ----------------------------------------------------------------------------
// One item is worked on at a time and every item gives one result beat.
// A load writes the backing memory at lookup; a hitting access reads the line,
// a missing access first refills it: the refill reads the byte-wide backing
// memory one byte a cycle for the 16 bytes of the line, and a drain step writes
// the last byte before the line read. The result sits in an output register, so
// the next item is accepted while an earlier result still waits to be taken.
// Backing memory bytes must be loaded before a refill reads them.
`default_nettype none

module direct_mapped_cache_read (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [dmc_pkg::IN_TDATA_W-1:0]      in_tdata,   // address, load_data
  input  wire                                 in_tuser,   // func
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [dmc_pkg::OUT_TDATA_W-1:0]     out_tdata,  // read_data, elapsed_time, miss_total
  output logic                                out_tuser   // was_miss
);
  import dmc_pkg::*;

  dmc_cmd_t          cmd;
  dmc_sts_t          sts;
  logic [DATA_W-1:0] rd_data;
  logic [CNT_W-1:0]  elapsed;
  logic [CNT_W-1:0]  miss_total;

  dmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dmc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_tuser),
    .in_addr          (in_tdata[ADDR_W-1:0]),
    .in_load_data     (in_tdata[ADDR_W +: DATA_W]),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_was_miss     (out_tuser),
    .out_read_data    (rd_data),
    .out_elapsed_time (elapsed),
    .out_miss_total   (miss_total)
  );

  assign out_tdata = OUT_TDATA_W'({miss_total, elapsed, rd_data});

endmodule

`default_nettype wire
